// ===== hdl/mea_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
// Used by mea_seq, modular_exponentiation_shift_add_unit and the testbench; depends on nothing.
package mea_pkg;

  localparam int IN_WIDTH      = 63;
  localparam int CFG_WIDTH     = 63;
  localparam int RESIDUE_WIDTH = 62;

  localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 63'd1000000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_FINISH
  } state_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic reduce_step;
    logic mul_start;
    logic mul_step;
    logic mul_last;
    logic emit;
  } ctrl_t;

endpackage

// ===== hdl/mea_step.sv =====
// One double-and-add step with modular correction: the shared arithmetic unit.
// Standalone; instantiated twice by modular_exponentiation_shift_add_unit.
module mea_step #(
  parameter int DATA_WIDTH = 63
) (
  input  logic [DATA_WIDTH-1:0] m,
  input  logic [DATA_WIDTH-1:0] acc,
  input  logic [DATA_WIDTH-1:0] addend,
  input  logic                  add_en,
  input  logic                  cin,
  output logic [DATA_WIDTH-1:0] acc_next,
  output logic [DATA_WIDTH-1:0] addend_next
);

  logic [DATA_WIDTH:0] m_ext;
  logic [DATA_WIDTH:0] sum;
  logic [DATA_WIDTH:0] dbl;

  assign m_ext = {1'b0, m};
  assign sum   = {1'b0, acc} + (add_en ? {1'b0, addend} : '0);
  // Doubling with a carry-in also serves as one restoring division step.
  assign dbl   = {addend, cin};

  always_comb begin
    if (sum >= m_ext) begin
      acc_next = DATA_WIDTH'(sum - m_ext);
    end else begin
      acc_next = sum[DATA_WIDTH-1:0];
    end
    if (dbl >= m_ext) begin
      addend_next = DATA_WIDTH'(dbl - m_ext);
    end else begin
      addend_next = dbl[DATA_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/mea_seq.sv =====
// Sequencer for the modular exponentiation unit: phase state and step counter.
// Depends on mea_pkg for the state and control types.
module mea_seq #(
  parameter int DATA_WIDTH = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           e_zero,
  input  logic           out_busy,
  output logic           in_ready,
  output mea_pkg::ctrl_t ctrl
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  mea_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             cnt_last;

  assign cnt_last = (cnt == CNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mea_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    ctrl       = '0;
    unique case (state)
      mea_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.accept = 1'b1;
          cnt_next    = '0;
          state_next  = mea_pkg::ST_REDUCE;
        end
      end
      mea_pkg::ST_REDUCE: begin
        ctrl.reduce_step = 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = mea_pkg::ST_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      mea_pkg::ST_CHECK: begin
        if (e_zero) begin
          state_next = mea_pkg::ST_FINISH;
        end else begin
          ctrl.mul_start = 1'b1;
          cnt_next       = '0;
          state_next     = mea_pkg::ST_MUL;
        end
      end
      mea_pkg::ST_MUL: begin
        ctrl.mul_step = 1'b1;
        if (cnt_last) begin
          ctrl.mul_last = 1'b1;
          cnt_next      = '0;
          state_next    = mea_pkg::ST_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      mea_pkg::ST_FINISH: begin
        // Hold the result until the output register is free.
        if (!out_busy) begin
          ctrl.emit  = 1'b1;
          state_next = mea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mea_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/modular_exponentiation_shift_add_unit.sv =====
// Modular exponentiation by right-to-left square-and-multiply, shift-and-add products.
// Each item runs a base reduction, then a check and a multiply pass per exponent bit up
// to the highest set bit of power, then a final check and the finish state.
// No new item is taken before the last result is emitted; two double-and-add units work one bit a cycle.
// Synchronous active-high reset clears the sequencer and output valid, and sets the
// modulus register to 1000000000. Depends on mea_pkg, mea_seq and mea_step.
module modular_exponentiation_shift_add_unit #(
  parameter int DATA_WIDTH = 63
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mea_pkg::IN_WIDTH-1:0]     base_value,
  input  logic [mea_pkg::IN_WIDTH-1:0]     power,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mea_pkg::RESIDUE_WIDTH-1:0] residue,
  input  logic                             modulus_valid,
  output logic                             modulus_ready,
  input  logic [mea_pkg::CFG_WIDTH-1:0]    modulus
);

  localparam logic [DATA_WIDTH-1:0] TOP_MOD = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] ONE     = DATA_WIDTH'(1);

  mea_pkg::ctrl_t ctrl;

  logic [mea_pkg::CFG_WIDTH-1:0] modulus_reg;
  logic [DATA_WIDTH-1:0] mod_low, m_eff;
  logic [DATA_WIDTH-1:0] m_reg;
  logic [DATA_WIDTH-1:0] sq, res, e, bin, bsh;
  logic [DATA_WIDTH-1:0] acc_a, add_a, acc_b, add_b;
  logic [DATA_WIDTH-1:0] a_acc_next, a_add_next, b_acc_next, b_add_next;
  logic [DATA_WIDTH-1:0] b_addend_in, res_red;
  logic [63:0]           res_wide;

  assign modulus_ready = 1'b1;

  // Zero counts as one, and a modulus above the top power of two saturates.
  assign mod_low = modulus_reg[DATA_WIDTH-1:0];
  assign m_eff   = (mod_low == '0) ? ONE : ((mod_low > TOP_MOD) ? TOP_MOD : mod_low);

  // The running product is below the modulus except for its initial one under modulus one.
  assign res_red  = (res >= m_reg) ? (res - m_reg) : res;
  assign res_wide = 64'(res);

  assign b_addend_in = ctrl.reduce_step ? sq : add_b;

  mea_seq #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .e_zero   (e == '0),
    .out_busy (out_valid && !out_ready),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // Multiply lane: running product times the current square.
  mea_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step_a (
    .m           (m_reg),
    .acc         (acc_a),
    .addend      (add_a),
    .add_en      (bsh[0]),
    .cin         (1'b0),
    .acc_next    (a_acc_next),
    .addend_next (a_add_next)
  );

  // Square lane; during base reduction its doubler does the restoring division.
  mea_step #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step_b (
    .m           (m_reg),
    .acc         (acc_b),
    .addend      (b_addend_in),
    .add_en      (bsh[0]),
    .cin         (ctrl.reduce_step & bin[DATA_WIDTH-1]),
    .acc_next    (b_acc_next),
    .addend_next (b_add_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg <= mea_pkg::MODULUS_RESET;
    end else if (modulus_valid) begin
      modulus_reg <= modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      m_reg <= m_eff;
      bin   <= base_value[DATA_WIDTH-1:0];
      e     <= power[DATA_WIDTH-1:0];
      sq    <= '0;
      res   <= ONE;
    end
    if (ctrl.reduce_step) begin
      sq  <= b_add_next;
      bin <= {bin[DATA_WIDTH-2:0], 1'b0};
    end
    if (ctrl.mul_start) begin
      acc_a <= '0;
      add_a <= res_red;
      acc_b <= '0;
      add_b <= sq;
      bsh   <= sq;
    end
    if (ctrl.mul_step) begin
      acc_a <= a_acc_next;
      add_a <= a_add_next;
      acc_b <= b_acc_next;
      add_b <= b_add_next;
      bsh   <= {1'b0, bsh[DATA_WIDTH-1:1]};
    end
    if (ctrl.mul_last) begin
      if (e[0]) begin
        res <= a_acc_next;
      end
      sq <= b_acc_next;
      e  <= {1'b0, e[DATA_WIDTH-1:1]};
    end
    if (ctrl.emit) begin
      residue <= res_wide[mea_pkg::RESIDUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sim/modular_exponentiation_shift_add_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench for modular_exponentiation_shift_add_unit: directed table, then random phases, each result
// checked against a pinned value or a square-and-multiply predictor. Depends on mea_pkg and the unit.
module modular_exponentiation_shift_add_unit_test;

  localparam logic [mea_pkg::CFG_WIDTH-1:0] MOD_TOP = 63'h4000_0000_0000_0000;
  localparam logic [mea_pkg::IN_WIDTH-1:0] ALL_ONES = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 15;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_CYCLES = 4200;

  typedef struct {
    bit                                set_mod;
    logic [mea_pkg::CFG_WIDTH-1:0]     mod_val;
    logic [mea_pkg::IN_WIDTH-1:0]      base_val;
    logic [mea_pkg::IN_WIDTH-1:0]      power_val;
    bit                                pinned;
    logic [mea_pkg::RESIDUE_WIDTH-1:0] want;
  } stim_row_t;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [mea_pkg::IN_WIDTH-1:0]      base_value;
  logic [mea_pkg::IN_WIDTH-1:0]      power;
  logic                              out_valid;
  logic                              out_ready;
  logic [mea_pkg::RESIDUE_WIDTH-1:0] residue;
  logic                              modulus_valid;
  logic                              modulus_ready;
  logic [mea_pkg::CFG_WIDTH-1:0]     modulus;

  logic [mea_pkg::CFG_WIDTH-1:0]     cfg_modulus;
  logic [mea_pkg::RESIDUE_WIDTH-1:0] pending_residues[$];
  stim_row_t                         directed_rows[$];
  bit                                pin_en;
  logic [mea_pkg::RESIDUE_WIDTH-1:0] pin_residue;
  bit                                hold_request;
  bit                                feed_steady;
  bit                                sink_steady;
  int                                error_count = 0;

  modular_exponentiation_shift_add_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .base_value    (base_value),
    .power         (power),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .residue       (residue),
    .modulus_valid (modulus_valid),
    .modulus_ready (modulus_ready),
    .modulus       (modulus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Right-to-left square-and-multiply with exact wide products.
  function automatic logic [mea_pkg::RESIDUE_WIDTH-1:0] modpow_residue(
    input logic [mea_pkg::CFG_WIDTH-1:0] mod_reg,
    input logic [mea_pkg::IN_WIDTH-1:0]  b,
    input logic [mea_pkg::IN_WIDTH-1:0]  p
  );
    logic [mea_pkg::CFG_WIDTH-1:0] m;
    logic [mea_pkg::IN_WIDTH-1:0]  e;
    logic [mea_pkg::CFG_WIDTH-1:0] sq;
    logic [mea_pkg::CFG_WIDTH-1:0] acc;
    logic [127:0]                  prod;
    m = mod_reg;
    if (m == '0) m = mea_pkg::CFG_WIDTH'(1);
    if (m > MOD_TOP) m = MOD_TOP;
    sq = b % m;
    acc = mea_pkg::CFG_WIDTH'(1);
    e = p;
    while (e != '0) begin
      if (e[0]) begin
        prod = 128'(acc) * 128'(sq);
        prod = prod % 128'(m);
        acc = prod[mea_pkg::CFG_WIDTH-1:0];
      end
      prod = 128'(sq) * 128'(sq);
      prod = prod % 128'(m);
      sq = prod[mea_pkg::CFG_WIDTH-1:0];
      e = e >> 1;
    end
    return acc[mea_pkg::RESIDUE_WIDTH-1:0];
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[62:0];
  endfunction

  task automatic add_row(input bit set_mod, input logic [mea_pkg::CFG_WIDTH-1:0] mod_val,
                         input logic [mea_pkg::IN_WIDTH-1:0] b,
                         input logic [mea_pkg::IN_WIDTH-1:0] p,
                         input bit pinned, input logic [mea_pkg::RESIDUE_WIDTH-1:0] want);
    stim_row_t r;
    r.set_mod = set_mod;
    r.mod_val = mod_val;
    r.base_val = b;
    r.power_val = p;
    r.pinned = pinned;
    r.want = want;
    directed_rows = {directed_rows, r};
  endtask

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [mea_pkg::IN_WIDTH-1:0] b,
                           input logic [mea_pkg::IN_WIDTH-1:0] p);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    base_value <= b;
    power <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_modulus(input logic [mea_pkg::CFG_WIDTH-1:0] v);
    modulus_valid <= 1'b1;
    modulus <= v;
    do @(posedge clk); while (!modulus_ready);
    @(negedge clk);
    modulus_valid <= 1'b0;
  endtask

  // Lowers the input valid and waits until every expected residue has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_residues.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_modulus <= mea_pkg::MODULUS_RESET;
    end else if (modulus_valid && modulus_ready) begin
      cfg_modulus <= modulus;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_residues = {pending_residues,
                          pin_en ? pin_residue
                                 : modpow_residue(cfg_modulus, base_value, power)};
    end
  end

  initial begin : result_sink
    int stall;
    logic [mea_pkg::RESIDUE_WIDTH-1:0] want;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (hold_request && !hold_done) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (rst || !out_valid);
      if (pending_residues.size() == 0) begin
        $display("%0t: unexpected residue transfer, expected none, got %h", $time, residue);
        error_count++;
      end else begin
        want = pending_residues.pop_front();
        if (residue !== want) begin
          $display("%0t: residue mismatch, expected %h, got %h", $time, want, residue);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    stim_row_t                     r;
    logic [mea_pkg::CFG_WIDTH-1:0] mod_val;
    logic [mea_pkg::IN_WIDTH-1:0]  b;
    logic [mea_pkg::IN_WIDTH-1:0]  p;
    rst = 1'b1;
    in_valid = 1'b0;
    base_value = '0;
    power = '0;
    modulus_valid = 1'b0;
    modulus = '0;
    pin_en = 1'b0;
    pin_residue = '0;
    hold_request = 1'b0;
    feed_steady = 1'b0;
    sink_steady = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Modulus after reset is one billion.
    add_row(1'b0, '0, 63'd0, 63'd0, 1'b1, 62'd1);
    add_row(1'b0, '0, 63'd2, 63'd10, 1'b1, 62'd1024);
    add_row(1'b0, '0, ALL_ONES, 63'd0, 1'b1, 62'd1);
    add_row(1'b0, '0, 63'd0, 63'd5, 1'b1, 62'd0);
    add_row(1'b0, '0, 63'd1000000003, 63'd1, 1'b1, 62'd3);
    add_row(1'b0, '0, 63'd12345, 63'd1, 1'b1, 62'd12345);
    add_row(1'b0, '0, ALL_ONES, ALL_ONES, 1'b0, '0);
    // A zero modulus behaves as modulus one.
    add_row(1'b1, 63'd0, 63'd7, 63'd0, 1'b1, 62'd1);
    add_row(1'b0, '0, 63'd7, 63'd3, 1'b1, 62'd0);
    // Modulus one still gives one for a zero exponent.
    add_row(1'b1, 63'd1, ALL_ONES, 63'd0, 1'b1, 62'd1);
    add_row(1'b0, '0, 63'd5, 63'd9, 1'b1, 62'd0);
    // Largest legal modulus.
    add_row(1'b1, MOD_TOP, 63'd3, 63'd2, 1'b1, 62'd9);
    add_row(1'b0, '0, ALL_ONES, 63'd1, 1'b1, 62'h3FFF_FFFF_FFFF_FFFF);
    add_row(1'b0, '0, 63'd2, 63'd62, 1'b1, 62'd0);
    add_row(1'b0, '0, 63'd2, 63'd61, 1'b1, 62'h2000_0000_0000_0000);
    add_row(1'b0, '0, ALL_ONES, ALL_ONES, 1'b0, '0);
    // Moduli above the top value saturate to it.
    add_row(1'b1, ALL_ONES, 63'd2, 63'd61, 1'b1, 62'h2000_0000_0000_0000);
    add_row(1'b0, '0, ALL_ONES, 63'd1, 1'b1, 62'h3FFF_FFFF_FFFF_FFFF);
    add_row(1'b1, 63'h4000_0000_0000_0001, 63'd2, 63'd62, 1'b1, 62'd0);
    add_row(1'b1, 63'h3FFF_FFFF_FFFF_FFFF, 63'd2, 63'd62, 1'b1, 62'd1);
    add_row(1'b0, '0, ALL_ONES, ALL_ONES, 1'b0, '0);
    // Prime modulus: Fermat's little theorem gives one.
    add_row(1'b1, 63'd1000000007, 63'd2, 63'd1000000006, 1'b1, 62'd1);
    add_row(1'b0, '0, 63'd0, 63'd0, 1'b1, 62'd1);
    add_row(1'b0, '0, 63'd1000000007, 63'd3, 1'b1, 62'd0);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.set_mod) begin
        settle();
        write_modulus(r.mod_val);
      end
      pin_en = r.pinned;
      pin_residue = r.want;
      send_item(r.base_val, r.power_val);
    end
    pin_en = 1'b0;
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: mod_val = rand63();
        1: mod_val = mea_pkg::CFG_WIDTH'($urandom_range(1, 1000));
        2: mod_val = {31'd0, $urandom()} | 63'd1;
        3: mod_val = rand63() >> 1;
        4: mod_val = MOD_TOP;
        5: mod_val = rand63() >> 33;
        6: mod_val = ALL_ONES;
        default: mod_val = '0;
      endcase
      write_modulus(mod_val);
      feed_steady = (ph % 3 == 1);
      sink_steady = (ph % 3 == 2);
      // Short exponents here so the block keeps finishing while the output is held off.
      if (ph == PRESSURE_PHASE) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 7))
          0: b = mea_pkg::IN_WIDTH'($urandom_range(0, 3));
          1: b = mod_val * mea_pkg::IN_WIDTH'($urandom_range(1, 3));
          default: b = rand63();
        endcase
        if (ph == PRESSURE_PHASE) begin
          p = mea_pkg::IN_WIDTH'($urandom_range(0, 15));
        end else if ($urandom_range(0, 3) == 0) begin
          p = rand63();
        end else begin
          p = rand63() >> (63 - $urandom_range(0, 16));
        end
        send_item(b, p);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_residues.size() != 0) begin
      $display("%0t: residues still outstanding, expected 0, got %0d", $time,
               pending_residues.size());
    end
    if (error_count == 0 && pending_residues.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mea_pkg.sv
hdl/mea_step.sv
hdl/mea_seq.sv
hdl/modular_exponentiation_shift_add_unit.sv
sim/modular_exponentiation_shift_add_unit_test.sv
